// ===== hw/rtl/mpvm_pkg.sv =====
`timescale 1ns / 1ps

package mpvm_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PUSHER_MASK = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIFT_MASK   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PUSHER_CRIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PUSHER_WARN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIFT_CRIT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LIFT_WARN   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = 3'd6;

	localparam logic [15:0] ALPHA_RESET = 16'd6554;

	// load status codes
	localparam logic [1:0] ST_INACTIVE = 2'd0;
	localparam logic [1:0] ST_NOMINAL  = 2'd1;
	localparam logic [1:0] ST_WARNING  = 2'd2;
	localparam logic [1:0] ST_CRITICAL = 2'd3;

	localparam logic [11:0] PWM_MIN = 12'd1000;
	localparam logic [11:0] PWM_MAX = 12'd2000;

	// floor(p / 1000) for p < 2^26 is (p * INT_RECIP) >> 36, low by at most one
	localparam int          DIV_CONST   = 1000;
	localparam int          INT_SHIFT   = 36;
	localparam logic [26:0] INT_RECIP   = 27'd68719476;
	// floor(t / 10) for t < 2^18 is exactly (t * CV_RECIP) >> 20
	localparam logic [16:0] CV_RECIP    = 17'd104858;
	localparam int          CV_SHIFT    = 20;
	localparam logic [15:0] CV_MAX      = 16'd6554;

	typedef struct packed {
		logic [2:0]  motor_index;
		logic [11:0] pwm_us;
		logic        pwm_valid;
		logic [15:0] battery_mv;
		logic        battery_valid;
	} mpvm_in_t;

	typedef struct packed {
		logic [2:0]         motor_id;
		logic signed [15:0] voltage_cv;
		logic [1:0]         load_status;
	} mpvm_out_t;

endpackage

// ===== hw/rtl/motor_phase_voltage_monitor_top.sv =====
`timescale 1ns / 1ps

// Per-motor phase voltage monitor. Each input beat carries one motor's PWM command
// and the battery reading; the block clamps the PWM to 1000..2000 us, forms the
// phase voltage battery_mv * duty in unsigned Q16.F millivolts, runs it through
// that motor's first-order low-pass filter (y += alpha * (x - y), alpha in Q0.16
// from the filter_alpha register) and returns one result beat with the filtered
// voltage in centivolts (rounded half up) and a load status graded against the
// class thresholds picked by the pusher and lift masks (pusher wins, a zero
// threshold is off). Items that are invalid, have zero duty or battery, name a
// motor beyond NUM_MOTORS or fall in neither mask return status inactive with zero
// voltage and leave the filter alone. Filter state lives in a single-port
// synchronous RAM, one word per motor, with a reset-cleared valid bit per word, so
// no clearing pass is needed. The sequencer walks each item through a shared
// datapath one arithmetic step per cycle (product, divide by 1000 in two
// reciprocal passes, filter difference, split alpha multiply, sum, write-back,
// output scaling), and it takes the next beat only after the write-back, once the
// result has entered the output register. A stalled output holds the result in
// the output register and adds the stall cycles. Configuration writes take effect
// at once and must be made while no item is in flight.
module motor_phase_voltage_monitor_top #(
	parameter int NUM_MOTORS       = 8,
	parameter int FILTER_FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  mpvm_pkg::mpvm_in_t                in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output mpvm_pkg::mpvm_out_t               out_data,
	input  logic                              cfg_wr_en,
	input  logic [mpvm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mpvm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import mpvm_pkg::*;

	localparam int F   = FILTER_FRAC_BITS;
	localparam int YW  = 16 + F;                 // filter word width, Q16.F
	localparam int AW  = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
	localparam int LW  = YW / 2;                 // low slice of the alpha multiply
	localparam int HW  = YW - LW;                // high slice
	localparam int PW  = 16 + YW;                // alpha * difference width
	localparam int RW  = F + 1;                  // fractional reciprocal width
	localparam int FMW = F + 11;                 // fractional product width
	// floor(r * 2^F / 1000) for r < 1000 is (r * FRAC_RECIP) >> 10, low by at most one
	localparam logic [RW-1:0] FRAC_RECIP = RW'((64'd1 << (F + 10)) / 64'd1000);

	typedef enum logic [3:0] {
		IDLE, PROD, QEST, QFIX, FEST, FFIX, DIFF, SCALE, SUM, UPDATE, RESULT
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [7:0]  pusher_mask_q, lift_mask_q;
	logic [15:0] pusher_crit_q, pusher_warn_q, lift_crit_q, lift_warn_q, alpha_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pusher_mask_q <= '0;
			lift_mask_q   <= '0;
			pusher_crit_q <= '0;
			pusher_warn_q <= '0;
			lift_crit_q   <= '0;
			lift_warn_q   <= '0;
			alpha_q       <= ALPHA_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_PUSHER_MASK: pusher_mask_q <= cfg_wdata[7:0];
				REG_LIFT_MASK:   lift_mask_q   <= cfg_wdata[7:0];
				REG_PUSHER_CRIT: pusher_crit_q <= cfg_wdata;
				REG_PUSHER_WARN: pusher_warn_q <= cfg_wdata;
				REG_LIFT_CRIT:   lift_crit_q   <= cfg_wdata;
				REG_LIFT_WARN:   lift_warn_q   <= cfg_wdata;
				REG_ALPHA:       alpha_q       <= cfg_wdata;
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

	// Input decode: clamp the PWM, find the duty and decide whether the item is live
	logic          accept;
	logic [11:0]   pwm_clamped;
	logic [9:0]    duty_in;
	logic          in_range, class_hit, active_in;
	logic [AW+2:0] idx_wide;
	logic [AW-1:0] addr_in;

	assign in_ready = (state_q == IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		if (in_data.pwm_us < PWM_MIN) begin
			pwm_clamped = PWM_MIN;
		end else if (in_data.pwm_us > PWM_MAX) begin
			pwm_clamped = PWM_MAX;
		end else begin
			pwm_clamped = in_data.pwm_us;
		end
		duty_in   = 10'(pwm_clamped - PWM_MIN);
		in_range  = (32'(in_data.motor_index) < NUM_MOTORS);
		class_hit = pusher_mask_q[in_data.motor_index] | lift_mask_q[in_data.motor_index];
		active_in = in_data.pwm_valid && in_data.battery_valid && (in_data.battery_mv != '0)
			&& in_range && (duty_in != '0) && class_hit;
		idx_wide  = (AW + 3)'(in_data.motor_index);
		addr_in   = idx_wide[AW-1:0];
	end

	// Item registers and datapath
	logic [2:0]      idx_q;
	logic [AW-1:0]   addr_q;
	logic [15:0]     bat_q;
	logic [9:0]      duty_q;
	logic            active_q;
	logic [25:0]     prod_q;
	logic [15:0]     qest_q, qint_q;
	logic [9:0]      rem_q;
	logic [F-1:0]    fest_q;
	logic [YW-1:0]   x_q, y_q, d_q, ynew_q;
	logic            neg_q;
	logic [16+LW-1:0] plo_q;
	logic [16+HW-1:0] phi_q;
	logic [PW-1:0]   acc_q;

	// Filter memory and the valid bit of each word
	logic [YW-1:0]         mem [NUM_MOTORS];
	logic [YW-1:0]         rd_data_q;
	logic                  rd_vld_q;
	logic [NUM_MOTORS-1:0] vld_q;
	logic                  mem_we;

	logic [25:0]     prod_c;
	logic [52:0]     qmul_c;
	logic [26:0]     qrem_c;
	logic [FMW-1:0]  fmul_c, frem_c;
	logic [F-1:0]    frac_c;
	logic [YW-1:0]   y_cur_c, step_c, ynew_c;
	logic [PW-1:0]   acc_c;

	always_comb begin
		prod_c  = 26'(bat_q) * 26'(duty_q);
		qmul_c  = 53'(prod_q) * 53'(INT_RECIP);
		qrem_c  = 27'(prod_q) - (27'(qest_q) * 27'(DIV_CONST));
		fmul_c  = FMW'(rem_q) * FMW'(FRAC_RECIP);
		frem_c  = (FMW'(rem_q) << F) - (FMW'(fest_q) * FMW'(DIV_CONST));
		frac_c  = (frem_c >= FMW'(DIV_CONST)) ? fest_q + F'(1) : fest_q;
		y_cur_c = rd_vld_q ? rd_data_q : '0;
		acc_c   = (PW'(phi_q) << LW) + PW'(plo_q) + (neg_q ? PW'(16'hFFFF) : '0);
		step_c  = acc_q[PW-1:16];
		ynew_c  = neg_q ? y_q - step_c : y_q + step_c;
	end

	assign mem_we = (state_q == UPDATE) && active_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr_q] <= ynew_c;
		end
		if (accept) begin
			rd_data_q <= mem[addr_in];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (mem_we) begin
			vld_q[addr_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q    <= in_data.motor_index;
			addr_q   <= addr_in;
			bat_q    <= in_data.battery_mv;
			duty_q   <= duty_in;
			active_q <= active_in;
			rd_vld_q <= vld_q[addr_in];
		end
		unique case (state_q)
			PROD: prod_q <= prod_c;
			QEST: qest_q <= qmul_c[INT_SHIFT+15:INT_SHIFT];
			QFIX: begin
				// estimate is low by at most one: fix it with one compare
				if (qrem_c >= 27'(DIV_CONST)) begin
					qint_q <= qest_q + 16'd1;
					rem_q  <= 10'(qrem_c - 27'(DIV_CONST));
				end else begin
					qint_q <= qest_q;
					rem_q  <= qrem_c[9:0];
				end
			end
			FEST: fest_q <= fmul_c[F+9:10];
			FFIX: x_q <= {qint_q, frac_c};
			DIFF: begin
				y_q   <= y_cur_c;
				neg_q <= (x_q < y_cur_c);
				d_q   <= (x_q < y_cur_c) ? y_cur_c - x_q : x_q - y_cur_c;
			end
			SCALE: begin
				plo_q <= (16 + LW)'(alpha_q) * (16 + LW)'(d_q[LW-1:0]);
				phi_q <= (16 + HW)'(alpha_q) * (16 + HW)'(d_q[YW-1:LW]);
			end
			SUM:    acc_q  <= acc_c;
			UPDATE: ynew_q <= ynew_c;
			default: ;
		endcase
	end

	// Output scaling and grading
	logic [16:0] cv_t_c;
	logic [33:0] cv_mul_c;
	logic [15:0] y_mv_c, crit_c, warn_c;
	logic [1:0]  status_c;
	mpvm_out_t   result_c;

	always_comb begin
		y_mv_c   = ynew_q[YW-1:F];
		cv_t_c   = 17'(y_mv_c) + 17'd5;
		cv_mul_c = 34'(cv_t_c) * 34'(CV_RECIP);
		if (pusher_mask_q[idx_q]) begin
			crit_c = pusher_crit_q;
			warn_c = pusher_warn_q;
		end else begin
			crit_c = lift_crit_q;
			warn_c = lift_warn_q;
		end
		priority if ((crit_c != '0) && (y_mv_c >= crit_c)) begin
			status_c = ST_CRITICAL;
		end else if ((warn_c != '0) && (y_mv_c >= warn_c)) begin
			status_c = ST_WARNING;
		end else begin
			status_c = ST_NOMINAL;
		end
		result_c.motor_id = idx_q;
		if (active_q) begin
			result_c.voltage_cv  = 16'(cv_mul_c[33:CV_SHIFT]);
			result_c.load_status = status_c;
		end else begin
			result_c.voltage_cv  = '0;
			result_c.load_status = ST_INACTIVE;
		end
	end

	// Sequencer and output register
	logic      out_valid_q;
	mpvm_out_t out_data_q;
	logic      out_load;

	assign out_load  = (state_q == RESULT) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// load a fresh result, or drop the beat once it is taken
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_data_q  <= result_c;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE:   if (accept) state_q <= PROD;
				PROD:   state_q <= QEST;
				QEST:   state_q <= QFIX;
				QFIX:   state_q <= FEST;
				FEST:   state_q <= FFIX;
				FFIX:   state_q <= DIFF;
				DIFF:   state_q <= SCALE;
				SCALE:  state_q <= SUM;
				SUM:    state_q <= UPDATE;
				UPDATE: state_q <= RESULT;
				RESULT: begin
					// hold until the output register is free
					if (out_load) begin
						state_q <= IDLE;
					end
				end
			endcase
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("input taken while an item is in flight");

	a_inactive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_data_q.load_status == ST_INACTIVE) |-> out_data_q.voltage_cv == '0)
		else $error("inactive result with nonzero voltage");

	a_cv_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q.voltage_cv >= 16'sd0) && (out_data_q.voltage_cv <= $signed(CV_MAX)))
		else $error("filtered voltage out of range");

	a_write_live: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> active_q && (32'(idx_q) < NUM_MOTORS))
		else $error("filter written for an inactive item");

	a_result_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q && (out_data_q.motor_id == $past(idx_q)))
		else $error("result beat lost or tagged with the wrong motor");

endmodule
